### rtl/core/smm_pkg.sv
// ----------------------------------------------------------------------------
// smm_pkg
// Shared constants for the square matrix multiply block: matrix geometry,
// field widths, word kinds and configuration register map.
// ----------------------------------------------------------------------------
`default_nettype none

package smm_pkg;

    // Matrix geometry
    localparam int MAX_DIM     = 16;
    localparam int DIM_W       = $clog2(MAX_DIM);
    localparam int SIZE_W      = 5;
    localparam int STORE_DEPTH = MAX_DIM * MAX_DIM;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);

    // Field widths
    localparam int KIND_W = 2;
    localparam int IDX_W  = 4;
    localparam int ELEM_W = 32;
    localparam int ACC_W  = 64;

    // Stream word widths
    localparam int S_DATA_W = 2 * IDX_W + ELEM_W;
    localparam int M_DATA_W = ACC_W + 2 * IDX_W;

    // Word kinds
    localparam logic [KIND_W-1:0] KIND_WR_A = 2'd0;
    localparam logic [KIND_W-1:0] KIND_WR_B = 2'd1;
    localparam logic [KIND_W-1:0] KIND_REQ  = 2'd2;

    // Configuration port
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_ADDR_W-1:0] REG_ACTIVE_SIZE = 1'b0;
    localparam logic [SIZE_W-1:0]     ACTIVE_SIZE_RST = 5'd16;

endpackage : smm_pkg

`default_nettype wire

### rtl/core/square_matrix_multiply.sv
// ----------------------------------------------------------------------------
// square_matrix_multiply
// Holds matrices A and B in two synchronous RAMs and returns one element of
// A x B per request, accumulated by a single shared 32x32 multiplier.
// ----------------------------------------------------------------------------
// Operation: an in-range request reads one RAM pair and does one
//   multiply-accumulate per term (n terms, n = active size, at most
//   MAX_DIM); an out-of-range request goes straight to the result stage.
// Flow: s_tready is high only when idle, so no new word is taken until the previous result is loaded.
// Reset: rst_n clears control state and sets active_size to 16; the matrix
//   RAMs are not cleared and hold garbage until written.
`default_nettype none

module square_matrix_multiply
    import smm_pkg::*;
(
    input  wire                   clk,
    input  wire                   rst_n,

    // Configuration port
    input  wire                   psel,
    input  wire                   penable,
    input  wire                   pwrite,
    input  wire  [CFG_ADDR_W-1:0] paddr,
    input  wire  [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready,

    // Input stream
    input  wire                   s_tvalid,
    output logic                  s_tready,
    input  wire  [S_DATA_W-1:0]   s_tdata,   // row[3:0], col[7:4], value[39:8]
    input  wire  [KIND_W-1:0]     s_tuser,   // kind[1:0]

    // Result stream
    output logic                  m_tvalid,
    input  wire                   m_tready,
    output logic [M_DATA_W-1:0]   m_tdata,   // product[63:0], out_row[67:64], out_col[71:68]
    output logic                  m_tuser    // bad_index[0]
);

    // Sequencer states
    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_RUN   = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    // Memories
    logic [ELEM_W-1:0] mem_a [STORE_DEPTH];
    logic [ELEM_W-1:0] mem_b [STORE_DEPTH];

    // Control state
    logic [1:0]        state_reg, state_next;
    logic [SIZE_W-1:0] active_size_reg;
    logic [DIM_W-1:0]  k_reg, k_next;
    logic              rd_vld_reg, rd_vld_next;
    logic              mul_vld_reg;
    logic              m_tvalid_reg;

    // Datapath state
    logic [IDX_W-1:0]  row_reg;
    logic [IDX_W-1:0]  col_reg;
    logic [SIZE_W-1:0] n_reg;
    logic              bad_reg;
    logic [ELEM_W-1:0] a_rdata_reg;
    logic [ELEM_W-1:0] b_rdata_reg;
    logic [ACC_W-1:0]  prod_reg;
    logic [ACC_W-1:0]  acc_reg;
    logic [M_DATA_W-1:0] m_tdata_reg;
    logic              m_tuser_reg;

    // Input fields
    logic [KIND_W-1:0] in_kind;
    logic [IDX_W-1:0]  in_row;
    logic [IDX_W-1:0]  in_col;
    logic [ELEM_W-1:0] in_value;
    logic [SIZE_W-1:0] eff_size;
    logic              in_inside;
    logic              in_accept;
    logic              wr_a, wr_b;
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] a_raddr, b_raddr;
    logic              last_term;
    logic              out_load;
    logic              cfg_wr;

    // Field unpacking and range check
    assign in_kind   = s_tuser;
    assign in_row    = s_tdata[IDX_W-1:0];
    assign in_col    = s_tdata[2*IDX_W-1:IDX_W];
    assign in_value  = s_tdata[S_DATA_W-1:2*IDX_W];
    assign eff_size  = (active_size_reg > SIZE_W'(MAX_DIM)) ? SIZE_W'(MAX_DIM)
                                                            : active_size_reg;
    assign in_inside = ({1'b0, in_row} < eff_size) && ({1'b0, in_col} < eff_size);

    assign s_tready  = (state_reg == ST_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign wr_a      = in_accept && in_inside && (in_kind == KIND_WR_A);
    assign wr_b      = in_accept && in_inside && (in_kind == KIND_WR_B);
    assign wr_addr   = {in_row[DIM_W-1:0], in_col[DIM_W-1:0]};

    // Read addresses: A walks along the row, B down the column
    assign a_raddr   = {row_reg[DIM_W-1:0], k_reg};
    assign b_raddr   = {k_reg, col_reg[DIM_W-1:0]};
    assign last_term = ({1'b0, k_reg} == (n_reg - SIZE_W'(1)));

    assign out_load  = (state_reg == ST_DONE) && (!m_tvalid_reg || m_tready);

    // Configuration port
    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;
    assign prdata = (paddr == REG_ACTIVE_SIZE)
                  ? {{(CFG_DATA_W-SIZE_W){1'b0}}, active_size_reg}
                  : '0;

    // Sequencer
    always_comb
    begin
        state_next  = state_reg;
        k_next      = k_reg;
        rd_vld_next = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                k_next = '0;
                if (in_accept && (in_kind == KIND_REQ))
                begin
                    state_next = in_inside ? ST_RUN : ST_DONE;
                end
            end
            ST_RUN:
            begin
                rd_vld_next = 1'b1;
                k_next      = k_reg + DIM_W'(1);
                if (last_term)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!rd_vld_reg && !mul_vld_reg)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            active_size_reg <= ACTIVE_SIZE_RST;
            k_reg           <= '0;
            rd_vld_reg      <= 1'b0;
            mul_vld_reg     <= 1'b0;
            m_tvalid_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            k_reg       <= k_next;
            rd_vld_reg  <= rd_vld_next;
            mul_vld_reg <= rd_vld_reg;
            if (cfg_wr && (paddr == REG_ACTIVE_SIZE))
            begin
                active_size_reg <= pwdata[SIZE_W-1:0];
            end
            if (out_load)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Matrix A RAM: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_a)
        begin
            mem_a[wr_addr] <= in_value;
        end
        a_rdata_reg <= mem_a[a_raddr];
    end

    // Matrix B RAM
    always_ff @(posedge clk)
    begin
        if (wr_b)
        begin
            mem_b[wr_addr] <= in_value;
        end
        b_rdata_reg <= mem_b[b_raddr];
    end

    // Request capture, multiply and accumulate
    always_ff @(posedge clk)
    begin
        if (in_accept && (in_kind == KIND_REQ))
        begin
            row_reg <= in_row;
            col_reg <= in_col;
            n_reg   <= eff_size;
            bad_reg <= !in_inside;
            acc_reg <= '0;
        end
        else if (mul_vld_reg)
        begin
            acc_reg <= acc_reg + prod_reg;
        end
        prod_reg <= ACC_W'($signed(a_rdata_reg) * $signed(b_rdata_reg));
    end

    // Output register
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            m_tdata_reg <= {col_reg, row_reg, acc_reg};
            m_tuser_reg <= bad_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule : square_matrix_multiply

`default_nettype wire
